// File: src/ssh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssh_pkg: shared types and constants of the swept ball segment hit test
// Fixed-point limits, register indexes, modes and the queue word layout.
// ----------------------------------------------------------------------------
package ssh_pkg;

	localparam int BNV_W  = 35;   // normal / tangent velocity, Q19.16
	localparam int BCPD_W = 36;   // centre distance from the line
	localparam int BND_W  = 37;   // contact distance
	localparam int DVD_W  = 53;   // |bnd| << 16
	localparam int DVS_W  = 35;   // |bnv| or twice the touch distance
	localparam int Q_W    = 31;   // quotient, hit time
	// Divider input register plus one stage per quotient bit.
	localparam int DIV_STAGES = Q_W + 1;

	localparam logic signed [BNV_W-1:0] LOW_NORMAL_SPEED = 35'sd655;
	localparam logic signed [BNV_W-1:0] CONTACT_SPEED    = 35'sd6554;
	localparam logic signed [BND_W-1:0] TOUCH_DISTANCE   = 37'sd6554;
	localparam logic signed [31:0]      ROLL_RADIUS_TOL  = 32'sd3277;
	localparam logic signed [52:0]      ENDPOINT_TOL     = 53'sd3277;
	localparam logic [Q_W-1:0]          HALF_TIME        = 31'd32768;

	localparam logic [1:0] MODE_OFF  = 2'd0;
	localparam logic [1:0] MODE_WALL = 2'd1;
	localparam logic [1:0] MODE_SPIN = 2'd2;
	localparam logic [1:0] MODE_TRIG = 2'd3;

	localparam logic [2:0] REG_MODE    = 3'd0;
	localparam logic [2:0] REG_START_X = 3'd1;
	localparam logic [2:0] REG_START_Y = 3'd2;
	localparam logic [2:0] REG_NORM_X  = 3'd3;
	localparam logic [2:0] REG_NORM_Y  = 3'd4;
	localparam logic [2:0] REG_LENGTH  = 3'd5;
	localparam logic [2:0] REG_Z_LOW   = 3'd6;
	localparam logic [2:0] REG_Z_HIGH  = 3'd7;

	// How the hit time is obtained.
	typedef enum logic [2:0] {
		TK_ZERO = 3'b001,   // time is zero
		TK_DIV  = 3'b010,   // distance over approach speed
		TK_NEAR = 3'b100    // near-touch ramp, quotient plus one half
	} tkind_t;

	// One classified ball, handed from the front to the back.
	typedef struct packed {
		logic              kill;
		tkind_t            kind;
		logic [DVD_W-1:0]  dividend;
		logic [DVS_W-1:0]  divisor;
		logic              unhit;
		logic              contact;
		logic [31:0]       contact_dist;
		logic [31:0]       nspeed;
		logic [BCPD_W-1:0] btd0;
		logic [BNV_W-1:0]  btv;
		logic [31:0]       bz;
		logic [31:0]       vz;
		logic [30:0]       rad;
		logic [30:0]       ftime;
	} work_t;

endpackage
`default_nettype wire

// File: src/ssh_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssh_front: projection and classification
// Projects velocity and offset on the segment normal and tangent, then
// decides for each ball how its hit time is found or whether it misses.
// ----------------------------------------------------------------------------
module ssh_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic signed [31:0]  ball_x,
	input  wire logic signed [31:0]  ball_y,
	input  wire logic signed [31:0]  ball_z,
	input  wire logic signed [31:0]  vel_x,
	input  wire logic signed [31:0]  vel_y,
	input  wire logic signed [31:0]  vel_z,
	input  wire logic [30:0]         ball_radius,
	input  wire logic [30:0]         frame_time,
	input  wire logic [2:0]          test_flags,
	input  wire logic [2:0]          ball_status,
	input  wire logic [1:0]          segment_mode,
	input  wire logic signed [31:0]  start_x,
	input  wire logic signed [31:0]  start_y,
	input  wire logic signed [15:0]  normal_x,
	input  wire logic signed [15:0]  normal_y,
	output logic                     out_valid,
	output ssh_pkg::work_t           out_word
);
	import ssh_pkg::*;

	// Stage 1: offsets and velocity products.
	logic               valid_s1;
	logic signed [32:0] dx_s1, dy_s1;
	logic signed [47:0] p_vxnx_s1, p_vyny_s1, p_vxny_s1, p_vynx_s1;
	logic [31:0]        bz_s1, vz_s1;
	logic [30:0]        rad_s1, ftime_s1;
	logic [2:0]         flags_s1, status_s1;

	// Stage 2: offset products, normal and tangent speed.
	logic               valid_s2;
	logic signed [48:0] p_dxnx_s2, p_dyny_s2, p_dxny_s2, p_dynx_s2;
	logic signed [BNV_W-1:0] bnv_s2, btv_s2;
	logic [31:0]        bz_s2, vz_s2;
	logic [30:0]        rad_s2, ftime_s2;
	logic [2:0]         flags_s2, status_s2;

	// Stage 3: distances.
	logic               valid_s3;
	logic signed [BCPD_W-1:0] bcpd_s3, btd0_s3;
	logic signed [BND_W-1:0]  bnd_s3;
	logic signed [BNV_W-1:0]  bnv_s3, btv_s3;
	logic [31:0]        bz_s3, vz_s3;
	logic [30:0]        rad_s3, ftime_s3;
	logic [2:0]         flags_s3, status_s3;

	logic signed [48:0] sum_v, sum_t;
	logic signed [49:0] sum_d, sum_b;
	logic signed [BCPD_W-1:0] bcpd_c;
	logic signed [31:0] rr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_comb begin
		sum_v  = 49'(p_vxnx_s1) + 49'(p_vyny_s1);
		sum_t  = 49'(p_vxny_s1) - 49'(p_vynx_s1);
		sum_d  = 50'(p_dxnx_s2) + 50'(p_dyny_s2);
		sum_b  = 50'(p_dxny_s2) - 50'(p_dynx_s2);
		bcpd_c = sum_d[49:14];
		rr     = flags_s2[1] ? $signed({1'b0, rad_s2}) : ROLL_RADIUS_TOL;
	end

	always_ff @(posedge clk) begin
		dx_s1     <= 33'(ball_x) - 33'(start_x);
		dy_s1     <= 33'(ball_y) - 33'(start_y);
		p_vxnx_s1 <= vel_x * normal_x;
		p_vyny_s1 <= vel_y * normal_y;
		p_vxny_s1 <= vel_x * normal_y;
		p_vynx_s1 <= vel_y * normal_x;
		bz_s1     <= ball_z;
		vz_s1     <= vel_z;
		rad_s1    <= ball_radius;
		ftime_s1  <= frame_time;
		flags_s1  <= test_flags;
		status_s1 <= ball_status;

		p_dxnx_s2 <= dx_s1 * normal_x;
		p_dyny_s2 <= dy_s1 * normal_y;
		p_dxny_s2 <= dx_s1 * normal_y;
		p_dynx_s2 <= dy_s1 * normal_x;
		bnv_s2    <= sum_v[48:14];
		btv_s2    <= sum_t[48:14];
		bz_s2     <= bz_s1;
		vz_s2     <= vz_s1;
		rad_s2    <= rad_s1;
		ftime_s2  <= ftime_s1;
		flags_s2  <= flags_s1;
		status_s2 <= status_s1;

		bcpd_s3   <= bcpd_c;
		btd0_s3   <= sum_b[49:14];
		bnd_s3    <= (segment_mode == MODE_SPIN) ? 37'(bcpd_c) + 37'(rr)
		                                         : 37'(bcpd_c) - 37'(rr);
		bnv_s3    <= bnv_s2;
		btv_s3    <= btv_s2;
		bz_s3     <= bz_s2;
		vz_s3     <= vz_s2;
		rad_s3    <= rad_s2;
		ftime_s3  <= ftime_s2;
		flags_s3  <= flags_s2;
		status_s3 <= status_s2;
	end

	// Classification of the stage 3 values.
	logic signed [BNV_W-1:0] abs_bnv;
	logic signed [BND_W-1:0] abs_bnd, rad_x;
	logic one_sided, lateral, rigid, unhit0, embedded, same_side, opposite;
	logic kill, unhit, contact;
	tkind_t kind;

	always_comb begin
		one_sided = flags_s3[0];
		lateral   = flags_s3[1];
		rigid     = flags_s3[2];
		abs_bnv   = bnv_s3[BNV_W-1] ? -bnv_s3 : bnv_s3;
		abs_bnd   = bnd_s3[BND_W-1] ? -bnd_s3 : bnd_s3;
		rad_x     = $signed({6'b0, rad_s3});
		unhit0    = bnv_s3 > LOW_NORMAL_SPEED;
		embedded  = bnd_s3 <= 0;
		opposite  = (bnd_s3 > 0 && bnv_s3 < 0) || (bnd_s3 < 0 && bnv_s3 > 0);
		same_side = !opposite;
		kill      = 1'b0;
		unhit     = unhit0;
		kind      = TK_DIV;
		if (rigid) begin
			if (bnd_s3 < -rad_x || (lateral && bcpd_s3 < 0)) begin
				kill = 1'b1;
			end else if (lateral && bnd_s3 <= TOUCH_DISTANCE) begin
				if (embedded || abs_bnv > CONTACT_SPEED || bnd_s3 <= -TOUCH_DISTANCE)
					kind = TK_ZERO;
				else
					kind = TK_NEAR;
			end else if (abs_bnv > LOW_NORMAL_SPEED) begin
				if (bnd_s3 == 0)
					kind = TK_ZERO;
				else if (!opposite)
					kill = 1'b1;
			end else begin
				kill = 1'b1;
			end
		end else begin
			if (same_side) begin
				kind  = TK_ZERO;
				unhit = !embedded;
				if (segment_mode != MODE_TRIG || !status_s3[1] ||
				    {abs_bnd, 1'b0} >= 38'(rad_x) || embedded == status_s3[2])
					kill = 1'b1;
			end
		end
		if (segment_mode == MODE_OFF || status_s3[0] || (one_sided && unhit0))
			kill = 1'b1;
		contact = abs_bnv <= CONTACT_SPEED && abs_bnd <= TOUCH_DISTANCE;
	end

	always_comb begin
		out_valid         = valid_s3;
		out_word.kill     = kill;
		out_word.kind     = kind;
		out_word.dividend = {16'(abs_bnd), 16'b0} | 53'({abs_bnd, 16'b0});
		out_word.divisor  = (kind == TK_NEAR) ? DVS_W'({TOUCH_DISTANCE, 1'b0})
		                                      : DVS_W'(abs_bnv);
		out_word.unhit    = !rigid && unhit;
		out_word.contact  = contact;
		if (bnd_s3 > 37'sd2147483647)
			out_word.contact_dist = 32'h7fff_ffff;
		else if (bnd_s3 < -37'sd2147483648)
			out_word.contact_dist = 32'h8000_0000;
		else
			out_word.contact_dist = bnd_s3[31:0];
		if (!contact)
			out_word.nspeed = 32'd0;
		else
			out_word.nspeed = bnv_s3[31:0];
		out_word.btd0     = btd0_s3;
		out_word.btv      = btv_s3;
		out_word.bz       = bz_s3;
		out_word.vz       = vz_s3;
		out_word.rad      = rad_s3;
		out_word.ftime    = ftime_s3;
	end

endmodule
`default_nettype wire

// File: src/ssh_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssh_queue: two-word queue between the front and the back
// Written at the tail, read and popped at the head whenever it holds a word.
// ----------------------------------------------------------------------------
module ssh_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire ssh_pkg::work_t push_word,
	input  wire logic           pop,
	output logic                not_empty,
	output logic                full,
	output ssh_pkg::work_t      head_word
);
	import ssh_pkg::*;

	work_t      mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] count_q;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	assign not_empty = count_q != 2'd0;
	assign full      = count_q == 2'd2;
	assign head_word = mem_q[rd_q];

endmodule
`default_nettype wire

// File: src/ssh_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssh_back: hit time division and endpoint and height checks
// A pipelined restoring divider, one quotient bit per stage, followed by
// the time products, the range checks and the result register.
// ----------------------------------------------------------------------------
module ssh_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire ssh_pkg::work_t     in_word,
	input  wire logic [30:0]        segment_length,
	input  wire logic signed [31:0] height_low,
	input  wire logic signed [31:0] height_high,
	output logic                    done,
	output logic                    hit,
	output logic [30:0]             hit_time,
	output logic signed [31:0]      hit_distance,
	output logic                    is_contact,
	output logic                    unhit,
	output logic signed [31:0]      normal_speed
);
	import ssh_pkg::*;

	logic             vld_s   [DIV_STAGES];
	work_t            w_s     [DIV_STAGES];
	logic [DVD_W-1:0] rem_s   [DIV_STAGES];
	logic [Q_W-1:0]   quo_s   [DIV_STAGES];
	logic [65:0]      shd     [Q_W];
	logic             ge      [Q_W];
	logic             ovf;
	work_t            w_in;

	always_comb begin
		ovf       = 66'(in_word.dividend) >= {in_word.divisor, 31'b0};
		w_in      = in_word;
		w_in.kill = in_word.kill || (in_word.kind != TK_ZERO && ovf);
		for (int k = 0; k < Q_W; k++) begin
			shd[k] = 66'(w_s[k].divisor) << (Q_W - 1 - k);
			ge[k]  = 66'(rem_s[k]) >= shd[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_STAGES; k++)
				vld_s[k] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
			for (int k = 0; k < Q_W; k++)
				vld_s[k+1] <= vld_s[k];
		end
	end

	always_ff @(posedge clk) begin
		w_s[0]      <= w_in;
		rem_s[0]    <= in_word.dividend;
		quo_s[0]    <= '0;
		for (int k = 0; k < Q_W; k++) begin
			w_s[k+1]   <= w_s[k];
			rem_s[k+1] <= ge[k] ? DVD_W'(66'(rem_s[k]) - shd[k]) : rem_s[k];
			quo_s[k+1] <= {quo_s[k][Q_W-2:0], ge[k]};
		end
	end

	// Tail: time select, products, sums, checks.
	logic             valid_s33, valid_s34, valid_s35;
	work_t            w_s33, w_s34, w_s35;
	logic [Q_W-1:0]   t_s33, t_s34, t_s35;
	logic             kill_s33, kill_s34, kill_s35;
	logic signed [50:0] p_bh_s34;
	logic signed [51:0] p_bl_s34;
	logic signed [47:0] p_zh_s34;
	logic signed [48:0] p_zl_s34;
	logic signed [52:0] btd_s35;
	logic signed [49:0] hitz_s35;
	logic [Q_W-1:0]   t_c;
	logic             fail;
	logic signed [52:0] rad_w, hz2;

	always_comb begin
		unique case (w_s[Q_W].kind)
			TK_ZERO: t_c = '0;
			TK_NEAR: t_c = quo_s[Q_W] + HALF_TIME;
			TK_DIV:  t_c = quo_s[Q_W];
			default: t_c = '0;
		endcase
		rad_w = $signed({22'b0, w_s35.rad});
		hz2   = $signed({hitz_s35, 1'b0}) + 53'sd0;
		fail  = kill_s35 ||
		        btd_s35 < -ENDPOINT_TOL ||
		        btd_s35 > $signed({22'b0, segment_length}) + ENDPOINT_TOL ||
		        hz2 + rad_w < $signed({height_low, 1'b0}) + 53'sd0 ||
		        hz2 - rad_w > $signed({height_high, 1'b0}) + 53'sd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s33 <= 1'b0;
			valid_s34 <= 1'b0;
			valid_s35 <= 1'b0;
			done      <= 1'b0;
		end else begin
			valid_s33 <= vld_s[Q_W];
			valid_s34 <= valid_s33;
			valid_s35 <= valid_s34;
			done      <= valid_s35;
		end
	end

	always_ff @(posedge clk) begin
		w_s33    <= w_s[Q_W];
		t_s33    <= t_c;
		kill_s33 <= w_s[Q_W].kill || t_c > w_s[Q_W].ftime;

		w_s34    <= w_s33;
		t_s34    <= t_s33;
		kill_s34 <= kill_s33;
		p_bh_s34 <= $signed(w_s33.btv) * $signed({1'b0, t_s33[30:16]});
		p_bl_s34 <= $signed(w_s33.btv) * $signed({1'b0, t_s33[15:0]});
		p_zh_s34 <= $signed(w_s33.vz) * $signed({1'b0, t_s33[30:16]});
		p_zl_s34 <= $signed(w_s33.vz) * $signed({1'b0, t_s33[15:0]});

		w_s35    <= w_s34;
		t_s35    <= t_s34;
		kill_s35 <= kill_s34;
		btd_s35  <= 53'($signed(w_s34.btd0)) + 53'(p_bh_s34)
		            + 53'($signed(p_bl_s34[51:16]));
		hitz_s35 <= 50'($signed(w_s34.bz)) + 50'(p_zh_s34)
		            + 50'($signed(p_zl_s34[48:16]));

		hit          <= !fail;
		hit_time     <= fail ? '0 : t_s35;
		hit_distance <= fail ? '0 : $signed(w_s35.contact_dist);
		is_contact   <= !fail && w_s35.contact;
		unhit        <= !fail && w_s35.unhit;
		normal_speed <= fail ? '0 : $signed(w_s35.nspeed);
	end

endmodule
`default_nettype wire

// File: src/swept_ball_segment_hit_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swept_ball_segment_hit_test: moving ball against one wall segment
// Tests each ball word against the configured segment and reports the hit.
// ----------------------------------------------------------------------------
// Usage. Load the segment through the configuration channel (cfg_valid,
// cfg_ready, cfg_index, cfg_data); cfg_ready is always high and a write
// lands at the edge where cfg_valid is high. Registers are only to be
// written while no ball word is in flight; the block does not enforce it.
// A ball word is taken at a rising edge where start is high and busy is
// low. One result word follows for every ball word, shown for exactly one
// cycle with done high; the receiver cannot stall it.
// From the accepting edge to the result the path runs through three front
// stages, the queue register, a 32-stage divider (an input register and one
// quotient bit per stage, the longest part of the path) and four tail
// stages for the time products, checks and result register.
// Throughput is one word per cycle while busy is low. The back part drains the two-word
// queue every cycle, so busy stays low in normal use.
// Reset clears all segment registers to zero (segment disabled) and empties
// the pipeline; no result is shown until a word is accepted.
// ----------------------------------------------------------------------------
module swept_ball_segment_hit_test (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] ball_x,
	input  wire logic signed [31:0] ball_y,
	input  wire logic signed [31:0] ball_z,
	input  wire logic signed [31:0] vel_x,
	input  wire logic signed [31:0] vel_y,
	input  wire logic signed [31:0] vel_z,
	input  wire logic [30:0]        ball_radius,
	input  wire logic [30:0]        frame_time,
	input  wire logic [2:0]         test_flags,
	input  wire logic [2:0]         ball_status,
	output logic                    done,
	output logic                    hit,
	output logic [30:0]             hit_time,
	output logic signed [31:0]      hit_distance,
	output logic                    is_contact,
	output logic                    unhit,
	output logic signed [31:0]      normal_speed,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);
	import ssh_pkg::*;

	// Segment registers.
	logic [1:0]         mode_q;
	logic signed [31:0] start_x_q, start_y_q, z_low_q, z_high_q;
	logic signed [15:0] normal_x_q, normal_y_q;
	logic [30:0]        length_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_OFF;
			start_x_q  <= '0;
			start_y_q  <= '0;
			normal_x_q <= '0;
			normal_y_q <= '0;
			length_q   <= '0;
			z_low_q    <= '0;
			z_high_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MODE:    mode_q     <= cfg_data[1:0];
				REG_START_X: start_x_q  <= cfg_data;
				REG_START_Y: start_y_q  <= cfg_data;
				REG_NORM_X:  normal_x_q <= cfg_data[15:0];
				REG_NORM_Y:  normal_y_q <= cfg_data[15:0];
				REG_LENGTH:  length_q   <= cfg_data[30:0];
				REG_Z_LOW:   z_low_q    <= cfg_data;
				REG_Z_HIGH:  z_high_q   <= cfg_data;
				default:     mode_q     <= mode_q;
			endcase
		end
	end

	// Front part: projections and classification.
	logic  front_valid;
	work_t front_word;
	logic  q_not_empty, q_full;
	work_t q_head;

	ssh_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (start && !busy),
		.ball_x       (ball_x),
		.ball_y       (ball_y),
		.ball_z       (ball_z),
		.vel_x        (vel_x),
		.vel_y        (vel_y),
		.vel_z        (vel_z),
		.ball_radius  (ball_radius),
		.frame_time   (frame_time),
		.test_flags   (test_flags),
		.ball_status  (ball_status),
		.segment_mode (mode_q),
		.start_x      (start_x_q),
		.start_y      (start_y_q),
		.normal_x     (normal_x_q),
		.normal_y     (normal_y_q),
		.out_valid    (front_valid),
		.out_word     (front_word)
	);

	// The queue is popped whenever it holds a word; the back never stalls.
	ssh_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_valid),
		.push_word (front_word),
		.pop       (q_not_empty),
		.not_empty (q_not_empty),
		.full      (q_full),
		.head_word (q_head)
	);

	assign busy = q_full;

	// Back part: division, time products, endpoint and height checks.
	ssh_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (q_not_empty),
		.in_word        (q_head),
		.segment_length (length_q),
		.height_low     (z_low_q),
		.height_high    (z_high_q),
		.done           (done),
		.hit            (hit),
		.hit_time       (hit_time),
		.hit_distance   (hit_distance),
		.is_contact     (is_contact),
		.unhit          (unhit),
		.normal_speed   (normal_speed)
	);

endmodule
`default_nettype wire
